>>> rtl/core/knts_pkg.sv
// ----------------------------------------------------------------------------
// knts_pkg
// Shared types and constants of the k-nearest-to-origin selector.
// ----------------------------------------------------------------------------
package knts_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned KEEP_W  = 5;

  // Register map: byte address of keep_count.
  localparam logic [2:0] ADDR_KEEP_COUNT = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_SCAN,
    ST_DECIDE,
    ST_POST,
    ST_RD,
    ST_LOAD,
    ST_PRESENT
  } knts_state_e;

  // One kept slot as stored in the RAM.
  typedef struct packed {
    logic [DIST_W-1:0]         dsq;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } knts_entry_t;

  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } knts_dist_req_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dsq;
  } knts_dist_rsp_t;

endpackage

>>> rtl/core/knts_ram.sv
// ----------------------------------------------------------------------------
// knts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module knts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/knts_dist.sv
// ----------------------------------------------------------------------------
// knts_dist
// Two-stage squared-distance unit: squares of the magnitudes, then the sum.
// ----------------------------------------------------------------------------
module knts_dist (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  knts_pkg::knts_dist_req_t req_i,
  output knts_pkg::knts_dist_rsp_t rsp_o
);

  import knts_pkg::*;

  logic [COORD_W-1:0]   mag_x;
  logic [COORD_W-1:0]   mag_y;
  logic [2*COORD_W-1:0] sq_x_q;
  logic [2*COORD_W-1:0] sq_y_q;
  logic [DIST_W-1:0]    sum_q;
  logic                 sq_vld_q;
  logic                 sum_vld_q;

  // Magnitude of -32768 is 32768, which still fits 16 unsigned bits.
  assign mag_x = req_i.x[COORD_W-1] ? COORD_W'(-req_i.x) : COORD_W'(req_i.x);
  assign mag_y = req_i.y[COORD_W-1] ? COORD_W'(-req_i.y) : COORD_W'(req_i.y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      sq_vld_q  <= req_i.start;
      sum_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sq_x_q <= mag_x * mag_x;
      sq_y_q <= mag_y * mag_y;
    end
    if (sq_vld_q) begin
      sum_q <= DIST_W'(sq_x_q + sq_y_q);
    end
  end

  assign rsp_o.valid = sum_vld_q;
  assign rsp_o.dsq   = sum_q;

endmodule

>>> rtl/core/knts_ctrl.sv
// ----------------------------------------------------------------------------
// knts_ctrl
// Sequencer: fills kept slots, scans for the farthest slot, replaces it with a
// nearer point, and emits the kept points through a registered output stage.
// ----------------------------------------------------------------------------
module knts_ctrl #(
  parameter int unsigned K_MAX = 16,
  localparam int unsigned CW   = $clog2(K_MAX + 1),
  localparam int unsigned AW   = (K_MAX > 1) ? $clog2(K_MAX) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CW-1:0]            k_eff_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
  input  logic                     s_axis_tlast,   // final_point
  // output stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata,   // [15:0] out_x, [31:16] out_y,
                                                   // [63:32] dist_sq
  output logic                     m_axis_tlast,   // end_of_run
  // distance unit
  output knts_pkg::knts_dist_req_t dist_req_o,
  input  knts_pkg::knts_dist_rsp_t dist_rsp_i,
  // kept-slot RAM
  output logic                     ram_we_o,
  output logic [AW-1:0]            ram_waddr_o,
  output knts_pkg::knts_entry_t    ram_wdata_o,
  output logic                     ram_re_o,
  output logic [AW-1:0]            ram_raddr_o,
  input  knts_pkg::knts_entry_t    ram_rdata_i
);

  import knts_pkg::*;

  knts_state_e state_q, state_d;

  logic [COORD_W-1:0] pt_x_q, pt_x_d;
  logic [COORD_W-1:0] pt_y_q, pt_y_d;
  logic               final_q, final_d;
  logic [DIST_W-1:0]  d_q, d_d;
  logic [CW-1:0]      k_q, k_d;
  logic [CW-1:0]      seen_q, seen_d;
  logic [CW-1:0]      n_q, n_d;
  logic [CW-1:0]      em_cnt_q, em_cnt_d;
  logic               sort_q, sort_d;
  logic [CW-1:0]      scan_addr_q, scan_addr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic               have_q, have_d;
  knts_entry_t        best_q, best_d;
  logic [AW-1:0]      best_idx_q, best_idx_d;
  logic [K_MAX-1:0]   done_q, done_d;
  logic               out_vld_q, out_vld_d;
  knts_entry_t        out_q, out_d;
  logic               out_last_q, out_last_d;

  logic               out_free;
  logic               take;
  logic               em_last;

  assign out_free = !out_vld_q || m_axis_tready;
  assign em_last  = (em_cnt_q + CW'(1)) == n_q;

  always_comb begin
    state_d     = state_q;
    pt_x_d      = pt_x_q;
    pt_y_d      = pt_y_q;
    final_d     = final_q;
    d_d         = d_q;
    k_d         = k_q;
    seen_d      = seen_q;
    n_d         = n_q;
    em_cnt_d    = em_cnt_q;
    sort_d      = sort_q;
    scan_addr_d = scan_addr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    have_d      = have_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    done_d      = done_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_d       = out_q;
    out_last_d  = out_last_q;
    take        = 1'b0;

    s_axis_tready    = (state_q == ST_IDLE);
    dist_req_o.start = 1'b0;
    dist_req_o.x     = s_axis_tdata[15:0];
    dist_req_o.y     = s_axis_tdata[31:16];

    ram_we_o         = 1'b0;
    ram_waddr_o      = best_idx_q;
    ram_wdata_o.x    = pt_x_q;
    ram_wdata_o.y    = pt_y_q;
    ram_wdata_o.dsq  = d_q;
    ram_re_o         = 1'b0;
    ram_raddr_o      = em_cnt_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          pt_x_d           = s_axis_tdata[15:0];
          pt_y_d           = s_axis_tdata[31:16];
          final_d          = s_axis_tlast;
          k_d              = k_eff_i;
          dist_req_o.start = 1'b1;
          state_d          = ST_DIST;
        end
      end

      ST_DIST: begin
        if (dist_rsp_i.valid) begin
          d_d = dist_rsp_i.dsq;
          if (seen_q < k_q && seen_q < CW'(K_MAX)) begin
            ram_we_o         = 1'b1;
            ram_waddr_o      = seen_q[AW-1:0];
            ram_wdata_o.dsq  = dist_rsp_i.dsq;
            seen_d           = seen_q + CW'(1);
            state_d          = ST_POST;
          end else begin
            sort_d      = 1'b0;
            scan_addr_d = '0;
            have_d      = 1'b0;
            state_d     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle; its data comes back in the next cycle.
        if (scan_addr_q < k_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = scan_addr_q[AW-1:0];
          rd_vld_d    = 1'b1;
          rd_idx_d    = scan_addr_q[AW-1:0];
          scan_addr_d = scan_addr_q + CW'(1);
        end
        if (rd_vld_q) begin
          // Strict compare keeps the lowest slot among equal distances.
          take = !(sort_q && done_q[rd_idx_q]) &&
                 (!have_q || ram_rdata_i.dsq > best_q.dsq);
          if (take) begin
            best_d     = ram_rdata_i;
            best_idx_d = rd_idx_q;
            have_d     = 1'b1;
          end
          if (CW'(rd_idx_q) == k_q - CW'(1)) begin
            state_d = sort_q ? ST_PRESENT : ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (d_q < best_q.dsq) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = best_idx_q;
        end
        state_d = ST_POST;
      end

      ST_POST: begin
        em_cnt_d = '0;
        if (!final_q) begin
          state_d = ST_IDLE;
        end else if (seen_q < k_q) begin
          sort_d  = 1'b0;
          n_d     = seen_q;
          state_d = ST_RD;
        end else begin
          sort_d      = 1'b1;
          n_d         = k_q;
          scan_addr_d = '0;
          have_d      = 1'b0;
          state_d     = ST_SCAN;
        end
      end

      ST_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = em_cnt_q[AW-1:0];
        state_d     = ST_LOAD;
      end

      ST_LOAD: begin
        best_d  = ram_rdata_i;
        state_d = ST_PRESENT;
      end

      ST_PRESENT: begin
        // Hold the word until the output stage has room.
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = best_q;
          out_last_d = em_last;
          if (sort_q) begin
            done_d[best_idx_q] = 1'b1;
          end
          if (em_last) begin
            seen_d  = '0;
            done_d  = '0;
            state_d = ST_IDLE;
          end else begin
            em_cnt_d = em_cnt_q + CW'(1);
            if (sort_q) begin
              scan_addr_d = '0;
              have_d      = 1'b0;
              state_d     = ST_SCAN;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seen_q    <= '0;
      done_q    <= '0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      sort_q    <= 1'b0;
      have_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      done_q    <= done_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= rd_vld_d;
      sort_q    <= sort_d;
      have_q    <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_x_q      <= pt_x_d;
    pt_y_q      <= pt_y_d;
    final_q     <= final_d;
    d_q         <= d_d;
    k_q         <= k_d;
    n_q         <= n_d;
    em_cnt_q    <= em_cnt_d;
    scan_addr_q <= scan_addr_d;
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.dsq, out_q.y, out_q.x};
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/core/k_nearest_to_origin_select.sv
// ----------------------------------------------------------------------------
// k_nearest_to_origin_select
// Keeps the k points of a stream nearest the origin and emits them on the
// last point of each set.
// ----------------------------------------------------------------------------
// A point that fills a free slot is written straight to it; a point that
// competes for a slot waits for a one-read-a-cycle scan of the kept slot RAM.
// On the final point the words are emitted sorted farthest first, or in input
// order when fewer than k slots were filled.
// Reset clears the sequencer and the fill count and sets keep_count to 5;
// the slot RAM is not cleared.
module k_nearest_to_origin_select #(
  parameter int unsigned K_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
  input  logic        s_axis_tlast,   // final_point
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] out_x, [31:16] out_y, [63:32] dist_sq
  output logic        m_axis_tlast    // end_of_run
);

  import knts_pkg::*;

  localparam int unsigned CW = $clog2(K_MAX + 1);
  localparam int unsigned AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int unsigned KW = (CW > KEEP_W) ? CW : KEEP_W;
  localparam int unsigned EW = $bits(knts_entry_t);

  logic [KEEP_W-1:0] keep_count_q;
  logic [KW-1:0]     keep_ext;
  logic [CW-1:0]     k_eff;

  knts_dist_req_t dist_req;
  knts_dist_rsp_t dist_rsp;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  knts_entry_t   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata_raw;
  knts_entry_t   ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_KEEP_COUNT) ? 32'(keep_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_W'(5);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_KEEP_COUNT) begin
      keep_count_q <= pwdata[KEEP_W-1:0];
    end
  end

  // Clamp k to 1..K_MAX.
  assign keep_ext = KW'(keep_count_q);
  always_comb begin
    if (keep_ext == '0) begin
      k_eff = CW'(1);
    end else if (keep_ext > KW'(K_MAX)) begin
      k_eff = CW'(K_MAX);
    end else begin
      k_eff = keep_ext[CW-1:0];
    end
  end

  knts_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dist_req),
    .rsp_o  (dist_rsp)
  );

  knts_ram #(
    .WIDTH (EW),
    .DEPTH (K_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = ram_rdata_raw;

  knts_ctrl #(
    .K_MAX (K_MAX)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .k_eff_i       (k_eff),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .dist_req_o    (dist_req),
    .dist_rsp_i    (dist_rsp),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

endmodule
